[hw/rtl/dip_pkg.sv]
// Package for the decimal integer parser: widths, character codes,
// configuration register indexes and overflow limits.
// No dependencies.
package dip_pkg;

  localparam int CHAR_W     = 8;
  localparam int VAL_W      = 64;
  localparam int DIG_W      = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CHAR_W-1:0] CH_SP   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB  = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT   = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF   = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9    = 8'h39;

  localparam logic [CFG_ADDR_W-1:0] REG_SIGNED_MODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WIDE_MODE     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DEFAULT_VALUE = 2'd2;

  localparam logic [VAL_W-1:0] LIM_U32     = 64'h0000_0000_FFFF_FFFF;
  localparam logic [VAL_W-1:0] LIM_U64     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] LIM_S32_POS = 64'h0000_0000_7FFF_FFFF;
  localparam logic [VAL_W-1:0] LIM_S32_NEG = 64'h0000_0000_8000_0000;
  localparam logic [VAL_W-1:0] LIM_S64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] LIM_S64_NEG = 64'h8000_0000_0000_0000;

endpackage

[hw/rtl/decimal_integer_parser_top.sv]
// Decimal integer parser: text bytes in, one parsed integer per text out.
// Depends on dip_pkg.
//
// Usage: send a text one byte per request on the in_ channel; in_tlast marks
// the final byte, in_tuser marks an empty-text request whose byte is ignored
// and which ends the text. Leading/trailing whitespace, an optional sign
// (minus only in signed mode) and decimal digits are accepted. At the end
// of each text one request leaves on the out_ channel: out_tdata holds the
// value (two's complement, negative values sign-extended) or the configured
// default; out_tuser is 1 on success.
// A request is held in the input register, then its result is loaded into
// the output register. The input takes one byte per cycle unless a byte
// ending a text waits on a stalled output; the multiply-by-ten, add and
// limit compare on the accumulator are combinational.
// When the receiver stalls, the output register holds its result and the
// input register keeps accepting bytes that produce no result; a byte that
// ends a text waits in the input register until the output register frees.
// Reset (rst_n low, synchronous) empties both registers, clears the parse
// state and sets signed mode, 32-bit width and a default of zero.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr
// (0 signed mode, 1 wide mode, 2 default value); write only while idle.
module decimal_integer_parser_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dip_pkg::CHAR_W-1:0]     in_tdata,   // [7:0] char_code
  input  logic                           in_tlast,   // last_char
  input  logic                           in_tuser,   // [0] empty_text
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [dip_pkg::VAL_W-1:0]      out_tdata,  // [63:0] value
  output logic                           out_tuser,  // [0] ok
  input  logic                           cfg_we,
  input  logic [dip_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dip_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dip_pkg::*;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGIT,
    PH_TRAIL,
    PH_FAIL
  } phase_t;

  logic              signed_r;
  logic              wide_r;
  logic [VAL_W-1:0]  default_r;

  logic              in_vld_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              in_last_r;
  logic              in_empty_r;

  phase_t            phase_r;
  logic              neg_r;
  logic [VAL_W-1:0]  acc_r;
  logic [VAL_W-1:0]  nacc_r;

  logic              out_vld_r;
  logic [VAL_W-1:0]  out_value_r;
  logic              out_ok_r;

  phase_t            ph_s;
  logic              neg_s;
  logic [VAL_W-1:0]  acc_s;
  logic [VAL_W-1:0]  nacc_s;
  logic              take_digit;
  logic              is_space;
  logic              is_digit;
  logic [DIG_W-1:0]  dig;
  logic [VAL_W-1:0]  lim;
  logic [VAL_W+3:0]  acc_ext;
  logic [VAL_W+3:0]  acc_sum;
  logic [VAL_W-1:0]  nacc_sum;
  logic              ovf;
  logic              gives_result;
  logic              res_ok;
  logic [VAL_W-1:0]  res_value;
  logic              out_free;
  logic              adv;
  logic              in_fire;

  assign is_space = in_char_r inside {CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  assign is_digit = in_char_r inside {[CH_0:CH_9]};
  assign dig      = in_char_r[DIG_W-1:0];

  always_comb begin
    if (signed_r) begin
      if (wide_r) begin
        lim = neg_r ? LIM_S64_NEG : LIM_S64_POS;
      end else begin
        lim = neg_r ? LIM_S32_NEG : LIM_S32_POS;
      end
    end else begin
      lim = wide_r ? LIM_U64 : LIM_U32;
    end
  end

  assign acc_ext  = {4'b0, acc_r};
  assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) + (VAL_W+4)'(dig);
  assign nacc_sum = (nacc_r << 3) + (nacc_r << 1) - VAL_W'(dig);
  assign ovf      = acc_sum > {4'b0, lim};

  always_comb begin
    ph_s       = phase_r;
    neg_s      = neg_r;
    acc_s      = acc_r;
    nacc_s     = nacc_r;
    take_digit = 1'b0;
    if (!in_empty_r) begin
      case (phase_r)
        PH_LEAD: begin
          if (!is_space) begin
            if (in_char_r == CH_PLUS) begin
              ph_s = PH_SIGN;
            end else if (in_char_r == CH_MINUS) begin
              if (signed_r) begin
                neg_s = 1'b1;
                ph_s  = PH_SIGN;
              end else begin
                ph_s = PH_FAIL;
              end
            end else if (is_digit) begin
              take_digit = 1'b1;
            end else begin
              ph_s = PH_FAIL;
            end
          end
        end
        PH_SIGN: begin
          if (is_digit) take_digit = 1'b1;
          else ph_s = PH_FAIL;
        end
        PH_DIGIT: begin
          if (is_digit) take_digit = 1'b1;
          else if (is_space) ph_s = PH_TRAIL;
          else ph_s = PH_FAIL;
        end
        PH_TRAIL: begin
          if (!is_space) ph_s = PH_FAIL;
        end
        default: begin
          ph_s = PH_FAIL;
        end
      endcase
      if (take_digit) begin
        if (ovf) begin
          ph_s = PH_FAIL;
        end else begin
          acc_s  = acc_sum[VAL_W-1:0];
          nacc_s = nacc_sum;
          ph_s   = PH_DIGIT;
        end
      end
    end
  end

  assign gives_result = in_empty_r | in_last_r;
  assign res_ok       = (ph_s == PH_DIGIT) || (ph_s == PH_TRAIL);
  assign res_value    = res_ok ? (neg_s ? nacc_s : acc_s) : default_r;

  assign out_free  = !out_vld_r || out_tready;
  assign adv       = in_vld_r && (!gives_result || out_free);
  assign in_tready = !in_vld_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_r  <= 1'b1;
      wide_r    <= 1'b0;
      default_r <= '0;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_LEAD;
      neg_r     <= 1'b0;
      acc_r     <= '0;
      nacc_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SIGNED_MODE:   signed_r  <= cfg_wdata[0];
          REG_WIDE_MODE:     wide_r    <= cfg_wdata[0];
          REG_DEFAULT_VALUE: default_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_fire) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv && gives_result) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (adv) begin
        if (gives_result) begin
          phase_r <= PH_LEAD;
          neg_r   <= 1'b0;
          acc_r   <= '0;
          nacc_r  <= '0;
        end else begin
          phase_r <= ph_s;
          neg_r   <= neg_s;
          acc_r   <= acc_s;
          nacc_r  <= nacc_s;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_char_r  <= in_tdata;
      in_last_r  <= in_tlast;
      in_empty_r <= in_tuser;
    end
    if (adv && gives_result) begin
      out_value_r <= res_value;
      out_ok_r    <= res_ok;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_ok_r;

  a_nacc_tracks_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r + nacc_r) == '0)
    else $error("negated accumulator out of step");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && gives_result |=> phase_r == PH_LEAD && acc_r == '0 && !neg_r)
    else $error("parse state not cleared after result");

  a_stalled_end_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && gives_result && !out_free |=> in_vld_r && $stable(in_char_r))
    else $error("ending request lost while output stalled");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    adv && gives_result |=> out_vld_r && out_ok_r == $past(res_ok))
    else $error("result not loaded into output register");

endmodule
